[rtl/qgi_pkg.sv]
`timescale 1ns / 1ps
package qgi_pkg;

    typedef struct packed {
        logic signed [31:0] rate_x;
        logic signed [31:0] rate_y;
        logic signed [31:0] rate_z;
        logic [23:0]        step_time;
    } qgi_in_t;

    typedef struct packed {
        logic signed [31:0] quat_w;
        logic signed [31:0] quat_x;
        logic signed [31:0] quat_y;
        logic signed [31:0] quat_z;
    } qgi_out_t;

    localparam logic signed [31:0] ONE_Q30 = 32'sh4000_0000;

    function automatic logic signed [31:0] sat32(input logic signed [67:0] x);
        if (x > 68'sh0_7FFF_FFFF)
            sat32 = 32'sh7FFF_FFFF;
        else if (x < -68'sh0_8000_0000)
            sat32 = -32'sh8000_0000;
        else
            sat32 = x[31:0];
    endfunction

endpackage

[rtl/qgi_fifo.sv]
`timescale 1ns / 1ps
module qgi_fifo
    import qgi_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    push,
    input  qgi_in_t push_data,
    output logic    full,
    input  logic    pop,
    output qgi_in_t pop_data,
    output logic    empty
);

    qgi_in_t    mem_reg [2];
    logic       wp_reg, rp_reg;
    logic [1:0] cnt_reg;

    assign full     = (cnt_reg == 2'd2);
    assign empty    = (cnt_reg == 2'd0);
    assign pop_data = mem_reg[rp_reg];

    always_ff @(posedge clk)
    begin
        if (push && !full)
            mem_reg[wp_reg] <= push_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= 1'b0;
            rp_reg  <= 1'b0;
            cnt_reg <= 2'd0;
        end
        else
        begin
            if (push && !full)
                wp_reg <= ~wp_reg;
            if (pop && !empty)
                rp_reg <= ~rp_reg;
            cnt_reg <= cnt_reg + 2'((push && !full) ? 1 : 0) - 2'((pop && !empty) ? 1 : 0);
        end
    end

    a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n) cnt_reg <= 2'd2)
        else $error("fifo count overflow");
    a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
        (empty && !push) |=> empty)
        else $error("fifo became nonempty without push");
    a_full_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (full && !pop) |=> full)
        else $error("fifo lost entry");

endmodule

[rtl/qgi_core.sv]
`timescale 1ns / 1ps
module qgi_core
    import qgi_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     start,
    input  qgi_in_t  item,
    output logic     busy,
    output logic     done,
    output qgi_out_t result
);

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_DELTA = 4'd1;
    localparam logic [3:0] S_D2    = 4'd2;
    localparam logic [3:0] S_A1    = 4'd3;
    localparam logic [3:0] S_A2    = 4'd4;
    localparam logic [3:0] S_T     = 4'd5;
    localparam logic [3:0] S_QM    = 4'd6;
    localparam logic [3:0] S_N2    = 4'd7;
    localparam logic [3:0] S_SQRT  = 4'd8;
    localparam logic [3:0] S_DIV   = 4'd9;
    localparam logic [3:0] S_DONE  = 4'd10;

    logic [3:0] state_reg, state_next;
    logic [4:0] idx_reg;
    logic [6:0] bit_reg;

    qgi_in_t            item_reg;
    logic signed [31:0] att_reg [4];
    logic signed [31:0] d_reg [3];
    logic signed [31:0] t_reg [3];
    logic signed [31:0] c_reg [4];
    logic signed [31:0] a_reg;
    logic [34:0]        d2_reg;
    logic [29:0]        q48_reg;
    logic [29:0]        s_reg;
    logic signed [35:0] acc_reg;
    logic [63:0]        n2_reg;
    logic [63:0]        rem_reg;
    logic [63:0]        root_reg;
    logic [63:0]        num_reg;
    logic [63:0]        dr_reg;
    logic [33:0]        quo_reg;

    // shared multiplier operands
    logic signed [35:0] mul_a, mul_b;
    logic signed [71:0] mul_p;
    logic signed [71:0] mq30;
    assign mul_p = mul_a * mul_b;
    assign mq30  = mul_p >>> 30;

    logic [1:0] qi, qj;
    assign qi = idx_reg[3:2];
    assign qj = idx_reg[1:0];

    // quaternion product term sign and left operand from (component, term)
    logic signed [31:0] lhs;
    logic               neg_term;
    always_comb
    begin
        lhs      = a_reg;
        neg_term = 1'b0;
        unique case ({qi, qj})
            4'h0: lhs = a_reg;
            4'h1: begin lhs = t_reg[0]; neg_term = 1'b1; end
            4'h2: begin lhs = t_reg[1]; neg_term = 1'b1; end
            4'h3: begin lhs = t_reg[2]; neg_term = 1'b1; end
            4'h4: lhs = t_reg[0];
            4'h5: lhs = a_reg;
            4'h6: lhs = t_reg[2];
            4'h7: begin lhs = t_reg[1]; neg_term = 1'b1; end
            4'h8: lhs = t_reg[1];
            4'h9: begin lhs = t_reg[2]; neg_term = 1'b1; end
            4'hA: lhs = a_reg;
            4'hB: lhs = t_reg[0];
            4'hC: lhs = t_reg[2];
            4'hD: lhs = t_reg[1];
            4'hE: begin lhs = t_reg[0]; neg_term = 1'b1; end
            4'hF: lhs = a_reg;
            default: lhs = a_reg;
        endcase
    end

    logic signed [31:0] rate_sel;
    always_comb
    begin
        case (idx_reg[1:0])
            2'd0:    rate_sel = item_reg.rate_x;
            2'd1:    rate_sel = item_reg.rate_y;
            default: rate_sel = item_reg.rate_z;
        endcase
    end

    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        unique case (state_reg)
            S_DELTA:
            begin
                mul_a = 36'(rate_sel);
                mul_b = 36'($signed({1'b0, item_reg.step_time}));
            end
            S_D2:
            begin
                mul_a = 36'(d_reg[idx_reg[1:0]]);
                mul_b = 36'(d_reg[idx_reg[1:0]]);
            end
            S_A1:
            begin
                // d2/48 = (d2 >> 4) / 3; reciprocal multiply is exact below 2^32
                mul_a = $signed({5'd0, d2_reg[34:4]});
                mul_b = 36'sh0_AAAA_AAAB;
            end
            S_A2:
            begin
                // d2/384 = (d2/48) >> 3
                mul_a = $signed({1'b0, d2_reg});
                mul_b = 36'sd134217728 - $signed({9'd0, q48_reg[29:3]});
            end
            S_T:
            begin
                mul_a = 36'(d_reg[idx_reg[1:0]]);
                mul_b = $signed({6'd0, s_reg});
            end
            S_QM:
            begin
                mul_a = 36'(lhs);
                mul_b = 36'(att_reg[qj]);
            end
            S_N2:
            begin
                mul_a = 36'(c_reg[idx_reg[1:0]]);
                mul_b = 36'(c_reg[idx_reg[1:0]]);
            end
            default: ;
        endcase
    end

    logic [63:0] bitv;
    assign bitv = 64'd1 << bit_reg[5:0];

    logic [64:0] sq_cmp;
    assign sq_cmp = {1'b0, rem_reg} - {1'b0, root_reg + bitv};

    // restoring divide step
    logic [64:0] div_sh;
    logic        div_qb;
    logic [63:0] div_rem;
    logic [33:0] quo_nxt;
    assign div_sh  = {dr_reg, num_reg[bit_reg[5:0]]};
    assign div_qb  = (div_sh >= {1'b0, root_reg});
    assign div_rem = div_qb ? 64'(div_sh - {1'b0, root_reg}) : div_sh[63:0];
    // bit 33 is sticky so an overflowing quotient still saturates
    assign quo_nxt = {quo_reg[32:0], div_qb} | {quo_reg[33], 33'd0};

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:  if (start) state_next = S_DELTA;
            S_DELTA: if (idx_reg == 5'd2) state_next = S_D2;
            S_D2:    if (idx_reg == 5'd2) state_next = S_A1;
            S_A1:    state_next = S_A2;
            S_A2:    state_next = S_T;
            S_T:     if (idx_reg == 5'd2) state_next = S_QM;
            S_QM:    if (idx_reg == 5'd15) state_next = S_N2;
            S_N2:    if (idx_reg == 5'd3) state_next = S_SQRT;
            S_SQRT:  if (bit_reg == 7'd0) state_next = S_DIV;
            S_DIV:
                if (root_reg == 64'd0 || (idx_reg == 5'd3 && bit_reg == 7'd0))
                    state_next = S_DONE;
            S_DONE:  state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    assign busy = (state_reg != S_IDLE);
    assign done = (state_reg == S_DONE);
    assign result = '{quat_w: att_reg[0], quat_x: att_reg[1],
                      quat_y: att_reg[2], quat_z: att_reg[3]};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            idx_reg    <= '0;
            bit_reg    <= '0;
            att_reg[0] <= ONE_Q30;
            att_reg[1] <= '0;
            att_reg[2] <= '0;
            att_reg[3] <= '0;
        end
        else
        begin
            state_reg <= state_next;
            unique case (state_reg)
                S_IDLE:
                begin
                    idx_reg <= '0;
                    if (start)
                        item_reg <= item;
                    d2_reg  <= '0;
                end
                S_DELTA:
                begin
                    d_reg[idx_reg[1:0]] <= sat32(68'(mul_p >>> 18));
                    idx_reg <= (idx_reg == 5'd2) ? 5'd0 : idx_reg + 5'd1;
                end
                S_D2:
                begin
                    d2_reg  <= d2_reg + 35'(mq30);
                    idx_reg <= (idx_reg == 5'd2) ? 5'd0 : idx_reg + 5'd1;
                end
                S_A1:
                begin
                    q48_reg <= mul_p[62:33];
                end
                S_A2:
                begin
                    a_reg <= sat32(68'(36'sh040000000) - 68'(mq30));
                    s_reg <= 30'd536870912 - q48_reg;
                end
                S_T:
                begin
                    t_reg[idx_reg[1:0]] <= sat32(68'(mq30));
                    idx_reg <= (idx_reg == 5'd2) ? 5'd0 : idx_reg + 5'd1;
                    acc_reg <= '0;
                end
                S_QM:
                begin
                    if (qj == 2'd3)
                    begin
                        c_reg[qi] <= sat32(68'(acc_reg) +
                            (neg_term ? -68'(mq30) : 68'(mq30)));
                        acc_reg <= '0;
                    end
                    else
                        acc_reg <= acc_reg + 36'(neg_term ? -mq30 : mq30);
                    idx_reg <= (idx_reg == 5'd15) ? 5'd0 : idx_reg + 5'd1;
                    n2_reg  <= '0;
                end
                S_N2:
                begin
                    n2_reg  <= n2_reg + 64'(mul_p[63:0] >> 2);
                    idx_reg <= (idx_reg == 5'd3) ? 5'd0 : idx_reg + 5'd1;
                    rem_reg <= n2_reg + 64'(mul_p[63:0] >> 2);
                    root_reg <= '0;
                    bit_reg <= 7'd62;
                end
                S_SQRT:
                begin
                    // one result bit per cycle (bit pairs of 2^62 down to 2^0)
                    if (!sq_cmp[64])
                    begin
                        rem_reg  <= sq_cmp[63:0];
                        root_reg <= (root_reg >> 1) + bitv;
                    end
                    else
                        root_reg <= root_reg >> 1;
                    if (bit_reg == 7'd0)
                    begin
                        idx_reg <= '0;
                        bit_reg <= 7'd63;
                        quo_reg <= '0;
                        num_reg <= {3'd0, (c_reg[0][31] ? 32'(-c_reg[0]) : c_reg[0]), 29'd0};
                        dr_reg  <= '0;
                    end
                    else
                        bit_reg <= bit_reg - 7'd2;
                end
                S_DIV:
                begin
                    // restoring divide, quotient capped at 34 bits of interest
                    if (root_reg != 64'd0)
                    begin
                        if (bit_reg == 7'd0)
                        begin
                            att_reg[idx_reg[1:0]] <= sat32(68'(c_reg[idx_reg[1:0]][31]
                                ? -$signed({1'b0, quo_nxt})
                                : $signed({1'b0, quo_nxt})));
                            idx_reg <= idx_reg + 5'd1;
                            bit_reg <= 7'd63;
                            quo_reg <= '0;
                            dr_reg  <= '0;
                            num_reg <= {3'd0, (c_reg[2'(idx_reg + 5'd1)][31]
                                ? 32'(-c_reg[2'(idx_reg + 5'd1)])
                                : c_reg[2'(idx_reg + 5'd1)]), 29'd0};
                        end
                        else
                        begin
                            dr_reg  <= div_rem;
                            quo_reg <= quo_nxt;
                            bit_reg <= bit_reg - 7'd1;
                        end
                    end
                end
                S_DONE: ;
                default: ;
            endcase
        end
    end

    a_done_one: assert property (@(posedge clk) disable iff (!rst_n) done |=> !done)
        else $error("done held");
    a_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> (state_reg == S_DELTA))
        else $error("start lost");
    a_sqrt_bit: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SQRT) |-> !bit_reg[0])
        else $error("sqrt bit odd");

endmodule

[rtl/quaternion_gyro_integrator_top.sv]
`timescale 1ns / 1ps
// Steps per input word, in order: delta angles, their squared norm, two Taylor terms,
// scaling, 16 quaternion product terms, the new norm, a bitwise square root, then
// four restoring divides on one shared divider and a done state; a zero norm ends the divide state at once.
// One word is processed at a time; the core waits until the held result is taken
// before it starts the next word. A two-word queue takes input ahead.
// Reset (rst_n async low) clears control and sets attitude to identity.
module quaternion_gyro_integrator_top
    import qgi_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     in_valid,
    output logic     in_ready,
    input  qgi_in_t  in_data,
    output logic     out_valid,
    input  logic     out_ready,
    output qgi_out_t out_data
);

    logic    q_full, q_empty, core_busy, core_done, core_start;
    qgi_in_t q_data;
    qgi_out_t core_res;
    logic    out_valid_reg;
    qgi_out_t out_data_reg;

    assign in_ready   = !q_full;
    assign core_start = !q_empty && !core_busy && !out_valid_reg;

    qgi_fifo u_fifo (
        .clk(clk), .rst_n(rst_n),
        .push(in_valid), .push_data(in_data), .full(q_full),
        .pop(core_start), .pop_data(q_data), .empty(q_empty)
    );

    qgi_core u_core (
        .clk(clk), .rst_n(rst_n),
        .start(core_start), .item(q_data),
        .busy(core_busy), .done(core_done), .result(core_res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (core_done)
            out_valid_reg <= 1'b1;
        else if (out_ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (core_done)
            out_data_reg <= core_res;
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=> out_valid)
        else $error("output dropped");
    a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
        core_done |-> !out_valid_reg)
        else $error("result overrun");
    a_start_free: assert property (@(posedge clk) disable iff (!rst_n)
        core_start |-> !core_busy)
        else $error("start while busy");

endmodule
